// ===== sv/lifo_stack_with_peek_unit_assert.svh =====
// ----------------------------------------------------------------------------
// lifo stack assertion macros
// implication checks that compile away when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LIFO_STACK_WITH_PEEK_UNIT_ASSERT_SVH
`define LIFO_STACK_WITH_PEEK_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define LSP_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lifo stack check failed");

// next-cycle implication
`define LSP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lifo stack check failed");

`else

`define LSP_ASSERT_SAME(label, clk, rst, ante, cons)
`define LSP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== sv/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lifo stack package
// operation and status codes, controller states and the command and status
// groups between controller and datapath
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int WORD_W  = 32;
   localparam int FUNC_W  = 2;
   localparam int INDEX_W = 5;
   localparam int COUNT_W = 5;

   // requested operation
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_PEEK = 2'd2
   } func_type;

   // result status
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2,
      ST_BADINDEX  = 2'd3
   } status_type;

   // source of the returned word
   typedef enum logic [1:0] {
      VSEL_ZERO = 2'd0,
      VSEL_ONE  = 2'd1,
      VSEL_NEG  = 2'd2,
      VSEL_MEM  = 2'd3
   } value_sel_type;

   // controller states, one-hot
   typedef enum logic [1:0] {
      CS_IDLE = 2'b01,
      CS_HOLD = 2'b10
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic          load;
      logic          write;
      logic          pop;
      logic          peek;
      value_sel_type value_sel;
      status_type    status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic peek_ok;
   } stat_type;

endpackage

// ===== sv/lifo_stack_with_peek_unit.sv =====
// ----------------------------------------------------------------------------
// lifo stack with peek
// push, pop and peek on a stack of DEPTH signed 32-bit words
// ----------------------------------------------------------------------------
// Each item's result appears in the cycle after the item is accepted, latched by
// the registered read port of the entry memory. A new item is taken in every
// cycle in which the previous result is taken or none is pending, so the
// block sustains one item per cycle and holds off the request side only while
// a result waits under stall. The returned count, empty and full flags reflect
// the stack after the operation. Memory entries need no clearing after reset:
// only entries written by an earlier push are ever read.
// ----------------------------------------------------------------------------
`include "lifo_stack_with_peek_unit_assert.svh"

module lifo_stack_with_peek_unit #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [lsp_pkg::FUNC_W-1:0]        req_func,
   input  logic signed [lsp_pkg::WORD_W-1:0] req_push_value,
   input  logic [lsp_pkg::INDEX_W-1:0]       req_peek_index,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [lsp_pkg::WORD_W-1:0] rsp_read_value,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic [lsp_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import lsp_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     accept;

   assign accept = req_valid && !req_stall;

   // control
   lsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_func  (req_func),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // storage and results
   lsp_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_push_value  (req_push_value),
      .req_peek_index  (req_peek_index),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_entry_count (rsp_entry_count)
   );

   // request side held off only behind a pending result
   `LSP_ASSERT_SAME(a_stall_needs_result, clock, reset, req_stall, rsp_valid)

   // push into a full stack reports overflow
   `LSP_ASSERT_NEXT(a_push_full_overflow, clock, reset,
      accept && (req_func == FUNC_PUSH) && stat.full,
      rsp_valid && (rsp_status == ST_OVERFLOW))

   // accepted pop removes one entry
   `LSP_ASSERT_NEXT(a_pop_decrements, clock, reset,
      accept && (req_func == FUNC_POP) && !stat.empty,
      rsp_valid && (rsp_status == ST_OK)
         && (rsp_entry_count == COUNT_W'($past(rsp_entry_count) - COUNT_W'(1))))

   // accepted item always leaves a result pending
   `LSP_ASSERT_NEXT(a_accept_gives_result, clock, reset, accept, rsp_valid)

endmodule

// ===== sv/lsp_ctrl.sv =====
// ----------------------------------------------------------------------------
// lifo stack controller
// decodes each accepted item into datapath commands and tracks the pending
// result in the output register
// ----------------------------------------------------------------------------
module lsp_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic [lsp_pkg::FUNC_W-1:0]       req_func,
   output logic                             req_stall,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   input  lsp_pkg::stat_type                stat,
   output lsp_pkg::cmd_type                 cmd
);
   import lsp_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // output register busy and not drained
   assign rsp_valid = (state_ff == CS_HOLD);
   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // state update
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE: begin
            if (accept) state_in = CS_HOLD;
         end
         CS_HOLD: begin
            if (accept) state_in = CS_HOLD;
            else if (!rsp_stall) state_in = CS_IDLE;
         end
         default: state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= CS_IDLE;
      else state_ff <= state_in;
   end

   // operation decode
   always_comb begin
      cmd           = '0;
      cmd.load      = accept;
      cmd.value_sel = VSEL_ZERO;
      cmd.status    = ST_OK;
      case (req_func)
         FUNC_PUSH: begin
            if (stat.full) cmd.status = ST_OVERFLOW;
            else cmd.write = accept;
         end
         FUNC_POP: begin
            if (stat.empty) begin
               cmd.status    = ST_UNDERFLOW;
               cmd.value_sel = VSEL_ONE;
            end else begin
               cmd.pop       = accept;
               cmd.value_sel = VSEL_MEM;
            end
         end
         FUNC_PEEK: begin
            if (stat.peek_ok) begin
               cmd.peek      = accept;
               cmd.value_sel = VSEL_MEM;
            end else begin
               cmd.status    = ST_BADINDEX;
               cmd.value_sel = VSEL_NEG;
            end
         end
         default: begin
            cmd.status    = ST_OK;
            cmd.value_sel = VSEL_ZERO;
         end
      endcase
   end

endmodule

// ===== sv/lsp_datapath.sv =====
// ----------------------------------------------------------------------------
// lifo stack datapath
// entry memory, held count, read register and result registers
// ----------------------------------------------------------------------------
module lsp_datapath #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  lsp_pkg::cmd_type                  cmd,
   output lsp_pkg::stat_type                 stat,
   input  logic signed [lsp_pkg::WORD_W-1:0] req_push_value,
   input  logic [lsp_pkg::INDEX_W-1:0]       req_peek_index,
   output logic signed [lsp_pkg::WORD_W-1:0] rsp_read_value,
   output logic [1:0]                        rsp_status,
   output logic                              rsp_is_empty,
   output logic                              rsp_is_full,
   output logic [lsp_pkg::COUNT_W-1:0]       rsp_entry_count
);
   import lsp_pkg::*;

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

   logic signed [WORD_W-1:0] mem_ff [DEPTH];
   logic signed [WORD_W-1:0] rd_ff;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   value_sel_type            value_sel_ff;
   status_type               status_ff;
   logic [CMP_W-1:0]         count_ext;
   logic [CMP_W-1:0]         index_ext;
   logic [CMP_W-1:0]         rd_pos;
   logic [ADDR_W-1:0]        rd_addr;
   logic [ADDR_W-1:0]        wr_addr;

   assign count_ext = CMP_W'(count_ff);
   assign index_ext = CMP_W'(req_peek_index);

   // flags seen by the controller
   assign stat.full    = (count_ff == CNT_W'(DEPTH));
   assign stat.empty   = (count_ff == '0);
   assign stat.peek_ok = (req_peek_index != '0) && (index_ext <= count_ext);

   // addresses: first free slot for push, top entry for pop, index counted down from the top for peek
   assign wr_addr = ADDR_W'(count_ff);
   assign rd_pos  = cmd.pop ? (count_ext - CMP_W'(1)) : (count_ext - index_ext);
   assign rd_addr = ADDR_W'(rd_pos);

   // entry memory with registered read
   always_ff @(posedge clock) begin
      if (cmd.write) mem_ff[wr_addr] <= req_push_value;
      if (cmd.pop || cmd.peek) rd_ff <= mem_ff[rd_addr];
   end

   // held count
   always_comb begin
      count_in = count_ff;
      if (cmd.write) count_in = count_ff + CNT_W'(1);
      else if (cmd.pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else count_ff <= count_in;
   end

   // result registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         value_sel_ff <= cmd.value_sel;
         status_ff    <= cmd.status;
      end
   end

   // returned word
   always_comb begin
      case (value_sel_ff)
         VSEL_ZERO: rsp_read_value = '0;
         VSEL_ONE:  rsp_read_value = 32'sd1;
         VSEL_NEG:  rsp_read_value = -32'sd1;
         VSEL_MEM:  rsp_read_value = rd_ff;
         default:   rsp_read_value = '0;
      endcase
   end

   assign rsp_status      = status_ff;
   assign rsp_is_empty    = stat.empty;
   assign rsp_is_full     = stat.full;
   assign rsp_entry_count = count_ext[COUNT_W-1:0];

endmodule

// ===== tb/lifo_stack_with_peek_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lifo stack with peek testbench
// drives push, pop and peek items through the valid/stall channels, tracks
// the stack contents in a local copy and compares every result field by
// field; a directed table comes first, then random traffic under three
// idling patterns
// ----------------------------------------------------------------------------
module lifo_stack_with_peek_unit_tb;
   import lsp_pkg::*;

   localparam int DEPTH          = 16;
   localparam int STACK_AW       = $clog2(DEPTH);
   localparam int RAND_PER_PHASE = 250;
   localparam int CYCLE_LIMIT    = 200000;

   // one result item as the block reports it
   typedef struct packed {
      logic signed [WORD_W-1:0] read_value;
      status_type               status;
      logic                     is_empty;
      logic                     is_full;
      logic [COUNT_W-1:0]       entry_count;
   } stack_rsp_type;

   // one row of the directed table
   typedef struct packed {
      func_type                 f;
      logic signed [WORD_W-1:0] value;
      logic [INDEX_W-1:0]       idx;
      logic [5:0]               reps;
      logic                     known;
      stack_rsp_type            want;
   } stim_row_type;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [FUNC_W-1:0]          req_func;
   logic signed [WORD_W-1:0]   req_push_value;
   logic [INDEX_W-1:0]         req_peek_index;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [WORD_W-1:0]   rsp_read_value;
   logic [1:0]                 rsp_status;
   logic                       rsp_is_empty;
   logic                       rsp_is_full;
   logic [COUNT_W-1:0]         rsp_entry_count;

   // local copy of the stack
   logic signed [WORD_W-1:0]   stack_words [DEPTH];
   int                         stack_used;

   stack_rsp_type              expected_rsps [$];
   stim_row_type               dir_rows [$];
   bit                         cur_known;
   stack_rsp_type              cur_want;
   int                         send_idle_pct;
   int                         recv_stall_pct;
   int                         error_count;
   int                         cycle_count;

   lifo_stack_with_peek_unit #(.DEPTH(DEPTH)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_func        (req_func),
      .req_push_value  (req_push_value),
      .req_peek_index  (req_peek_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full),
      .rsp_entry_count (rsp_entry_count)
   );

   // clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // apply one operation to the local stack and return its result
   function automatic stack_rsp_type stack_apply(logic [FUNC_W-1:0] f,
                                                 logic signed [WORD_W-1:0] v,
                                                 logic [INDEX_W-1:0] idx);
      stack_rsp_type r;
      int            pos;
      r.read_value = '0;
      r.status     = ST_OK;
      if (f == FUNC_PUSH) begin
         if (stack_used >= DEPTH) begin
            r.status = ST_OVERFLOW;
         end else begin
            stack_words[stack_used[STACK_AW-1:0]] = v;
            stack_used++;
         end
      end else if (f == FUNC_POP) begin
         if (stack_used == 0) begin
            r.read_value = 1;
            r.status     = ST_UNDERFLOW;
         end else begin
            stack_used--;
            r.read_value = stack_words[stack_used[STACK_AW-1:0]];
         end
      end else if (f == FUNC_PEEK) begin
         if (idx == 0 || idx > stack_used) begin
            r.read_value = -1;
            r.status     = ST_BADINDEX;
         end else begin
            pos          = stack_used - int'(idx);
            r.read_value = stack_words[pos[STACK_AW-1:0]];
         end
      end
      r.is_empty    = (stack_used == 0);
      r.is_full     = (stack_used == DEPTH);
      r.entry_count = stack_used[COUNT_W-1:0];
      return r;
   endfunction

   // table row whose result comes from the local stack
   function automatic void plan(func_type f, logic signed [WORD_W-1:0] v,
                                logic [INDEX_W-1:0] idx, int reps);
      stim_row_type row;
      row       = '0;
      row.f     = f;
      row.value = v;
      row.idx   = idx;
      row.reps  = reps[5:0];
      dir_rows.push_back(row);
   endfunction

   // table row with its result written out
   function automatic void plan_known(func_type f, logic signed [WORD_W-1:0] v,
                                      logic [INDEX_W-1:0] idx,
                                      logic signed [WORD_W-1:0] w_val,
                                      status_type w_st, int w_empty, int w_full,
                                      int w_cnt);
      stim_row_type row;
      row                  = '0;
      row.f                = f;
      row.value            = v;
      row.idx              = idx;
      row.reps             = 6'd1;
      row.known            = 1'b1;
      row.want.read_value  = w_val;
      row.want.status      = w_st;
      row.want.is_empty    = w_empty[0];
      row.want.is_full     = w_full[0];
      row.want.entry_count = w_cnt[COUNT_W-1:0];
      dir_rows.push_back(row);
   endfunction

   // offer one item, with a random gap first, and wait for its acceptance
   task automatic send_item(func_type f, logic signed [WORD_W-1:0] v,
                            logic [INDEX_W-1:0] idx, bit known, stack_rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_func       <= f;
      req_push_value <= v;
      req_peek_index <= idx;
      cur_known = known;
      cur_want  = want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver stall
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // track accepted items and check accepted results
   always @(posedge clock) begin
      stack_rsp_type pred;
      stack_rsp_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pred = stack_apply(req_func, req_push_value, req_peek_index);
            expected_rsps.push_back(cur_known ? cur_want : pred);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result item with nothing expected");
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_read_value !== want.read_value) begin
                  $error("read_value: expected %0d, got %0d", want.read_value,
                         rsp_read_value);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_status);
                  error_count++;
               end
               if (rsp_is_empty !== want.is_empty) begin
                  $error("is_empty: expected %0d, got %0d", want.is_empty,
                         rsp_is_empty);
                  error_count++;
               end
               if (rsp_is_full !== want.is_full) begin
                  $error("is_full: expected %0d, got %0d", want.is_full, rsp_is_full);
                  error_count++;
               end
               if (rsp_entry_count !== want.entry_count) begin
                  $error("entry_count: expected %0d, got %0d", want.entry_count,
                         rsp_entry_count);
                  error_count++;
               end
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lifo_stack_with_peek_unit test failed");
         $finish;
      end
   end

   // stimulus
   initial begin
      func_type                 f;
      logic signed [WORD_W-1:0] v;
      logic [INDEX_W-1:0]       idx;
      int                       push_bias;
      int                       roll;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_func       = FUNC_PUSH;
      req_push_value = '0;
      req_peek_index = '0;
      rsp_stall      = 1'b0;
      stack_used     = 0;
      error_count    = 0;
      cycle_count    = 0;
      cur_known      = 1'b0;
      cur_want       = '0;
      send_idle_pct  = 36;
      recv_stall_pct = 60;
      for (int i = 0; i < DEPTH; i++) stack_words[i[STACK_AW-1:0]] = '0;

      // directed table: empty stack, extremes, full stack, bad indexes
      plan_known(FUNC_POP,  -1, 5'd16, 1, ST_UNDERFLOW, 1, 0, 0);
      plan_known(FUNC_PEEK, 0, 5'd1, -1, ST_BADINDEX, 1, 0, 0);
      plan_known(FUNC_PEEK, 0, 5'd0, -1, ST_BADINDEX, 1, 0, 0);
      plan_known(FUNC_PUSH, 32'sh7fff_ffff, 5'd0, 0, ST_OK, 0, 0, 1);
      plan_known(FUNC_PUSH, 32'sh8000_0000, 5'd16, 0, ST_OK, 0, 0, 2);
      plan_known(FUNC_PEEK, 0, 5'd1, 32'sh8000_0000, ST_OK, 0, 0, 2);
      plan_known(FUNC_PEEK, 0, 5'd2, 32'sh7fff_ffff, ST_OK, 0, 0, 2);
      plan_known(FUNC_PEEK, 0, 5'd3, -1, ST_BADINDEX, 0, 0, 2);
      plan_known(FUNC_POP,  -1, 5'd16, 32'sh8000_0000, ST_OK, 0, 0, 1);
      plan_known(FUNC_POP,  -1, 5'd16, 32'sh7fff_ffff, ST_OK, 1, 0, 0);
      plan(FUNC_PUSH, 32'sh1234_0000, 5'd0, DEPTH);
      plan_known(FUNC_PUSH, -1, 5'd0, 0, ST_OVERFLOW, 0, 1, 16);
      plan(FUNC_PEEK, 0, 5'd16, 1);
      plan_known(FUNC_PEEK, 0, 5'd0, -1, ST_BADINDEX, 0, 1, 16);
      plan(FUNC_PEEK, 0, 5'd1, 1);
      plan(FUNC_POP, 0, 5'd0, 1);
      plan_known(FUNC_PUSH, -1, 5'd31, 0, ST_OK, 0, 1, 16);
      plan(FUNC_POP, 0, 5'd0, DEPTH);
      plan_known(FUNC_POP,  0, 5'd0, 1, ST_UNDERFLOW, 1, 0, 0);
      plan_known(FUNC_PUSH, 0, 5'd0, 0, ST_OK, 0, 0, 1);
      plan_known(FUNC_PEEK, 0, 5'd16, -1, ST_BADINDEX, 0, 0, 1);
      plan_known(FUNC_PEEK, -1, 5'd1, 0, ST_OK, 0, 0, 1);
      plan(FUNC_POP, 0, 5'd0, 1);

      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_rows[i]) begin
         for (int k = 0; k < dir_rows[i].reps; k++) begin
            send_item(dir_rows[i].f, dir_rows[i].value + k, dir_rows[i].idx,
                      dir_rows[i].known, dir_rows[i].want);
         end
      end

      // random traffic, one phase per idling pattern
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_idle_pct  = 36;
               recv_stall_pct = 60;
            end
            1: begin
               send_idle_pct  = 60;
               recv_stall_pct = 36;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         push_bias = 50;
         for (int n = 0; n < RAND_PER_PHASE; n++) begin
            // bursts lean toward filling or draining the stack
            if (n % 32 == 0) push_bias = 20 + 30 * $urandom_range(2);
            v = $urandom;
            if ($urandom_range(9) == 0) begin
               case ($urandom_range(3))
                  0: v = 32'sh7fff_ffff;
                  1: v = 32'sh8000_0000;
                  2: v = 0;
                  default: v = -1;
               endcase
            end
            idx  = INDEX_W'($urandom_range(16));
            roll = $urandom_range(99);
            if (roll < 25) begin
               f = FUNC_PEEK;
               // mostly in-range distances, the rest one past the top or anywhere from 0 to 16
               if (stack_used > 0 && $urandom_range(9) < 7)
                  idx = INDEX_W'($urandom_range(stack_used, 1));
               else if ($urandom_range(1) == 0)
                  idx = (stack_used < DEPTH) ? INDEX_W'(stack_used + 1) : '0;
            end else if ($urandom_range(99) < push_bias) begin
               f = FUNC_PUSH;
            end else begin
               f = FUNC_POP;
            end
            send_item(f, v, idx, 1'b0, '0);
         end
         // hold off until every result of this phase has come back
         req_valid <= 1'b0;
         do @(negedge clock); while (expected_rsps.size() != 0);
      end

      repeat (4) @(negedge clock);
      if (error_count == 0) begin
         $display("lifo_stack_with_peek_unit test passed");
      end else begin
         $display("lifo_stack_with_peek_unit test failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/lsp_pkg.sv
sv/lsp_ctrl.sv
sv/lsp_datapath.sv
sv/lifo_stack_with_peek_unit.sv
tb/lifo_stack_with_peek_unit_tb.sv
